// File: hdl/sro_pkg.sv
// shared constants, types and the quarter-wave sine rom for the sine range oscillator
package sro_pkg;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int PHASE_BITS       = 16;

    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 2;
    localparam int ADDR_W    = REG_IDX_W + 2;

    // quarter-wave indexing
    localparam int FRAC_W  = PHASE_BITS - 2;
    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int IPROD_W = FRAC_W + IDX_W;

    // divider: 32-bit magnitude followed by PHASE_BITS zero bits
    localparam int DIV_STEPS = DATA_W + PHASE_BITS;

    // scaling: h = sine + one, a Q17 fraction of one
    localparam int SINE_W  = 17;
    localparam int H_W     = 18;
    localparam int H_SHIFT = 17;
    localparam int MUL_W   = DATA_W + 1 + H_W + 1;
    localparam logic [H_W-1:0] Q16_ONE = H_W'(65536);

    localparam logic [DATA_W-1:0] PERIOD_START_RST = 32'd0;
    localparam logic [DATA_W-1:0] PERIOD_END_RST   = 32'd65536;
    localparam logic [DATA_W-1:0] AMP_MIN_RST      = 32'd0;
    localparam logic [DATA_W-1:0] AMP_MAX_RST      = 32'd65536;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PERIOD_START,
        REG_PERIOD_END,
        REG_AMP_MIN,
        REG_AMP_MAX
    } reg_idx_t;

    typedef struct packed {
        logic              valid;
        logic              neg;
        logic [DATA_W-1:0] mag;
    } div_in_t;

    typedef struct packed {
        logic                  valid;
        logic                  neg;
        logic [PHASE_BITS-1:0] quo;
        logic                  rem_nz;
    } div_out_t;

    // sine table, built at elaboration from a fixed-point taylor series
    typedef logic [SINE_W-1:0] sine_word_t;
    typedef sine_word_t sine_rom_t [0:SINE_TABLE_DEPTH];

    localparam logic [63:0] Q30_ONE    = 64'h0000_0000_4000_0000;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] DEPTH_64   = 64'(SINE_TABLE_DEPTH);
    localparam logic [63:0] HORNER_DIV [0:5] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            x  = (HALF_PI_Q30 * 64'(k)) / DEPTH_64;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            for (int n = 0; n < 6; n++)
            begin
                t = Q30_ONE - (((x2 * t) >> 30) / HORNER_DIV[n]);
            end
            s = (x * t) >> 30;
            q = (s + 64'd8192) >> 14;
            if (q > 64'd65536)
            begin
                q = 64'd65536;
            end
            rom[k] = SINE_W'(q);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// File: hdl/sro_arg_if.sv
// argument channel: valid, ready and one signed q16.16 argument word
interface sro_arg_if
    import sro_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] argument;

    modport source (output valid, output argument, input ready);
    modport sink   (input valid, input argument, output ready);
endinterface

// File: hdl/sro_wave_if.sv
// wave channel: valid, ready, scaled sine value and period error flag
interface sro_wave_if
    import sro_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] wave_value;
    logic                     period_error;

    modport source (output valid, output wave_value, output period_error, input ready);
    modport sink   (input valid, input wave_value, input period_error, output ready);
endinterface

// File: hdl/sro_divider.sv
// pipelined restoring divider, one quotient bit per stage, keeps the low phase bits
module sro_divider
    import sro_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic [DATA_W-1:0] divisor,
    input  div_in_t           div_in,
    output div_out_t          div_out
);

    typedef struct packed {
        logic                  neg;
        logic [DATA_W-1:0]     rem;
        logic [DATA_W-1:0]     num;
        logic [PHASE_BITS-1:0] quo;
    } div_stage_t;

    div_stage_t             stage_reg  [DIV_STEPS];
    div_stage_t             stage_next [DIV_STEPS];
    logic [DIV_STEPS-1:0]   valid_reg;
    logic [DIV_STEPS-1:0]   valid_next;
    div_stage_t             seed;

    // one trial subtract, quotient bit shifted in at the bottom
    function automatic div_stage_t div_step(div_stage_t src, logic [DATA_W-1:0] dvs);
        div_stage_t      res;
        logic [DATA_W:0] trial;
        trial   = {src.rem, src.num[DATA_W-1]} - {1'b0, dvs};
        res.neg = src.neg;
        res.num = {src.num[DATA_W-2:0], 1'b0};
        res.quo = {src.quo[PHASE_BITS-2:0], ~trial[DATA_W]};
        if (!trial[DATA_W])
        begin
            res.rem = trial[DATA_W-1:0];
        end
        else
        begin
            res.rem = {src.rem[DATA_W-2:0], src.num[DATA_W-1]};
        end
        return res;
    endfunction

    always_comb
    begin
        seed.neg      = div_in.neg;
        seed.rem      = '0;
        seed.num      = div_in.mag;
        seed.quo      = '0;
        stage_next[0] = div_step(seed, divisor);
        valid_next[0] = div_in.valid;
        for (int s = 1; s < DIV_STEPS; s++)
        begin
            stage_next[s] = div_step(stage_reg[s-1], divisor);
            valid_next[s] = valid_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    assign div_out.valid  = valid_reg[DIV_STEPS-1];
    assign div_out.neg    = stage_reg[DIV_STEPS-1].neg;
    assign div_out.quo    = stage_reg[DIV_STEPS-1].quo;
    assign div_out.rem_nz = |stage_reg[DIV_STEPS-1].rem;

endmodule

// File: hdl/sine_range_oscillator_unit.sv
// top level of the sine range oscillator: config registers and the evaluation pipeline
// The unit takes one signed Q16.16 argument word per clock and returns, for each, one word
// amp_min + (amp_max - amp_min) * (sin(2*pi*(argument - period_start) / (period_end -
// period_start)) + 1) / 2, also signed Q16.16, read from a quarter-wave table without
// interpolation. Throughput is one word per cycle while no result word is held; an accepted
// argument reaches its result word through one input stage, a 48-stage restoring divider
// that produces one quotient bit per stage (32 argument bits followed by the 16 phase bits),
// then phase/index, table, multiply and output stages. The whole pipeline advances together,
// so a held result word stalls every stage and the argument ready drops with it. When
// period_end equals period_start the result is amp_min with period_error set. The four
// registers sit at byte addresses 0, 4, 8 and 12 of the apb port and should be written only
// while no words are in flight; there is no memory to clear after reset.
module sine_range_oscillator_unit
    import sro_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    sro_arg_if.sink           arg_ch,
    sro_wave_if.source        wave_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam logic [IDX_W-1:0] DEPTH_IDX  = IDX_W'(SINE_TABLE_DEPTH);
    localparam logic [IDX_W-1:0] DEPTH_LAST = IDX_W'(SINE_TABLE_DEPTH - 1);

    // configuration registers
    logic [DATA_W-1:0] period_start_reg;
    logic [DATA_W-1:0] period_end_reg;
    logic [DATA_W-1:0] amp_min_reg;
    logic [DATA_W-1:0] amp_max_reg;
    reg_idx_t          reg_idx;
    logic              cfg_write;

    // values derived from the configuration and registered, so they follow it in the next cycle
    logic [DATA_W:0]          len_next;
    logic [DATA_W:0]          len_abs;
    logic [DATA_W-1:0]        lmag_reg;
    logic                     lneg_reg;
    logic                     lzero_reg;
    logic signed [DATA_W:0]   diff_reg;
    logic signed [DATA_W:0]   diff_next;

    // global advance: the pipeline moves whenever the output word can go
    logic adv;

    // input stage
    logic              arg_valid_reg;
    logic              dneg_reg;
    logic [DATA_W-1:0] dmag_reg;
    logic [DATA_W:0]   d_next;
    logic [DATA_W:0]   d_abs;
    div_in_t           div_in;
    div_out_t          div_out;

    // phase and table index stage
    logic                  ph_valid_reg;
    logic [IDX_W-1:0]      k_reg;
    logic [IDX_W-1:0]      k_next;
    logic                  sneg_reg;
    logic [PHASE_BITS-1:0] phase;
    logic [PHASE_BITS-1:0] phase_pos;
    logic [IPROD_W-1:0]    idx_prod;
    logic [IDX_W-1:0]      idx;

    // table stage
    logic             rom_valid_reg;
    logic [H_W-1:0]   h_reg;
    logic [H_W-1:0]   h_next;
    sine_word_t       sine_mag;

    // multiply stage
    logic                    mul_valid_reg;
    logic signed [MUL_W-1:0] prod_reg;
    logic signed [MUL_W-1:0] prod_next;

    // output stage
    logic              wave_valid_reg;
    logic [DATA_W-1:0] wave_value_reg;
    logic [DATA_W-1:0] wave_value_next;
    logic              wave_err_reg;

    // apb port, always ready, writes land on the access cycle
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_start_reg <= PERIOD_START_RST;
            period_end_reg   <= PERIOD_END_RST;
            amp_min_reg      <= AMP_MIN_RST;
            amp_max_reg      <= AMP_MAX_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_PERIOD_START: period_start_reg <= pwdata;
                REG_PERIOD_END:   period_end_reg   <= pwdata;
                REG_AMP_MIN:      amp_min_reg      <= pwdata;
                REG_AMP_MAX:      amp_max_reg      <= pwdata;
                default:          period_start_reg <= period_start_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PERIOD_START: prdata = period_start_reg;
            REG_PERIOD_END:   prdata = period_end_reg;
            REG_AMP_MIN:      prdata = amp_min_reg;
            REG_AMP_MAX:      prdata = amp_max_reg;
            default:          prdata = '0;
        endcase
    end

    // period length as sign and magnitude, and the amplitude span
    always_comb
    begin
        len_next  = {period_end_reg[DATA_W-1], period_end_reg}
                  - {period_start_reg[DATA_W-1], period_start_reg};
        len_abs   = len_next[DATA_W] ? -len_next : len_next;
        diff_next = signed'({amp_max_reg[DATA_W-1], amp_max_reg}
                  - {amp_min_reg[DATA_W-1], amp_min_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lmag_reg  <= PERIOD_END_RST - PERIOD_START_RST;
            lneg_reg  <= 1'b0;
            lzero_reg <= 1'b0;
            diff_reg  <= signed'({1'b0, AMP_MAX_RST - AMP_MIN_RST});
        end
        else
        begin
            lmag_reg  <= len_abs[DATA_W-1:0];
            lneg_reg  <= len_next[DATA_W];
            lzero_reg <= (len_next == '0);
            diff_reg  <= diff_next;
        end
    end

    assign adv          = !wave_valid_reg || wave_ch.ready;
    assign arg_ch.ready = adv;

    // input stage: offset from the period start, as sign and magnitude
    always_comb
    begin
        d_next = {arg_ch.argument[DATA_W-1], arg_ch.argument}
               - {period_start_reg[DATA_W-1], period_start_reg};
        d_abs  = d_next[DATA_W] ? -d_next : d_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arg_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            arg_valid_reg <= arg_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dneg_reg <= d_next[DATA_W];
            dmag_reg <= d_abs[DATA_W-1:0];
        end
    end

    assign div_in.valid = arg_valid_reg;
    assign div_in.neg   = dneg_reg;
    assign div_in.mag   = dmag_reg;

    sro_divider u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .divisor (lmag_reg),
        .div_in  (div_in),
        .div_out (div_out)
    );

    // floor quotient modulo one period: a negative quotient rounds away from zero
    always_comb
    begin
        phase_pos = div_out.quo + PHASE_BITS'(div_out.rem_nz);
        if (div_out.neg ^ lneg_reg)
        begin
            phase = PHASE_BITS'(0) - phase_pos;
        end
        else
        begin
            phase = div_out.quo;
        end
        idx_prod = IPROD_W'(phase[FRAC_W-1:0]) * IPROD_W'(DEPTH_IDX);
        idx      = idx_prod[FRAC_W +: IDX_W];
        if (idx >= DEPTH_IDX)
        begin
            idx = DEPTH_LAST;
        end
        // odd quadrants run the table backwards
        k_next = phase[PHASE_BITS-2] ? (DEPTH_IDX - idx) : idx;
    end

    // table read and offset to a q17 fraction of one
    always_comb
    begin
        sine_mag = SINE_ROM[k_reg];
        if (sneg_reg)
        begin
            h_next = Q16_ONE - H_W'(sine_mag);
        end
        else
        begin
            h_next = Q16_ONE + H_W'(sine_mag);
        end
    end

    assign prod_next = diff_reg * signed'({1'b0, h_reg});

    // shift is a floor for either sign; zero length forces the trough value
    always_comb
    begin
        if (lzero_reg)
        begin
            wave_value_next = amp_min_reg;
        end
        else
        begin
            wave_value_next = amp_min_reg + prod_reg[H_SHIFT +: DATA_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_valid_reg   <= 1'b0;
            rom_valid_reg  <= 1'b0;
            mul_valid_reg  <= 1'b0;
            wave_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ph_valid_reg   <= div_out.valid;
            rom_valid_reg  <= ph_valid_reg;
            mul_valid_reg  <= rom_valid_reg;
            wave_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k_reg          <= k_next;
            sneg_reg       <= phase[PHASE_BITS-1];
            h_reg          <= h_next;
            prod_reg       <= prod_next;
            wave_value_reg <= wave_value_next;
            wave_err_reg   <= lzero_reg;
        end
    end

    assign wave_ch.valid        = wave_valid_reg;
    assign wave_ch.wave_value   = signed'(wave_value_reg);
    assign wave_ch.period_error = wave_err_reg;

`ifndef SYNTHESIS
    // a zero-length period gives the trough value with the flag set
    a_zero_len_word: assert property (@(posedge clk) disable iff (!rst_n)
        adv && mul_valid_reg && lzero_reg |=>
            wave_ch.period_error && (wave_value_reg == $past(amp_min_reg)))
        else $error("zero period length word not forced to amp_min");

    // a held output word freezes the tail of the pipeline
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable({ph_valid_reg, rom_valid_reg, mul_valid_reg, wave_valid_reg}))
        else $error("pipeline moved during a stall");

    // an advance hands the multiply stage word to the output
    a_advance_moves: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> (wave_valid_reg == $past(mul_valid_reg)))
        else $error("output valid lost or invented on advance");

    // the argument ready follows the output stage
    a_ready_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        wave_ch.valid && !wave_ch.ready |-> !arg_ch.ready)
        else $error("argument taken while result word held");
`endif

endmodule

// File: tb/sine_range_oscillator_unit_tb.sv
// self-checking testbench for the sine range oscillator: directed table, random phases, scoreboard
`timescale 1ns / 100ps

module sine_range_oscillator_unit_tb
    import sro_pkg::*;
;

    // q30 constants of the quarter-wave series
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam longint unsigned UNIT_Q30         = 64'd1 << 30;
    localparam int unsigned     TAYLOR_DIV [0:5] = '{156, 110, 72, 42, 20, 6};

    localparam int RANDOM_PHASES   = 10;
    localparam int WORDS_PER_PHASE = 140;
    localparam int DRAIN_CYCLES    = 60;
    localparam int TIMEOUT_NS      = 10_000_000;

    typedef enum logic [1:0] {QUAD_RISE, QUAD_FALL, QUAD_DIP, QUAD_CLIMB} quadrant_t;
    typedef enum logic {ROW_WRITE, ROW_ARGUMENT} row_kind_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              err;
    } wave_word_t;

    typedef struct packed {
        row_kind_t         kind;
        reg_idx_t          target;
        logic [DATA_W-1:0] word;
        logic              typed;
        logic [DATA_W-1:0] want_value;
        logic              want_err;
    } stim_row_t;

    // directed table: register writes and argument words, expected word typed in where obvious
    localparam int DIRECTED_COUNT = 36;
    localparam stim_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
        // reset setting: one unit period, output between 0 and 1
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'h0000_0000, 1'b1, 32'h0000_8000, 1'b0},
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'h0000_4000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'h0000_8000, 1'b1, 32'h0000_8000, 1'b0},
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'h0000_C000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
        // zero period length: amp_min with the error flag
        '{ROW_WRITE,    REG_PERIOD_START, 32'h0003_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE,    REG_PERIOD_END,   32'h0003_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE,    REG_AMP_MIN,      32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE,    REG_AMP_MAX,      32'h7FFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'h0003_0000, 1'b1, 32'h8000_0000, 1'b1},
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b1},
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1},
        // widest period with the amplitude range inverted
        '{ROW_WRITE,    REG_PERIOD_START, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE,    REG_PERIOD_END,   32'h7FFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE,    REG_AMP_MIN,      32'h7FFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE,    REG_AMP_MAX,      32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'hC000_0000, 1'b0, 32'h0000_0000, 1'b0},
        // reversed unit period, phase runs backwards, arguments outside the period wrap
        '{ROW_WRITE,    REG_PERIOD_START, 32'h0001_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE,    REG_PERIOD_END,   32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE,    REG_AMP_MIN,      32'hFFFF_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE,    REG_AMP_MAX,      32'h0001_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'h0000_4000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'h0001_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'hFFFF_C000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'h0002_0000, 1'b0, 32'h0000_0000, 1'b0},
        // tiny period and a flat amplitude range
        '{ROW_WRITE,    REG_PERIOD_START, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE,    REG_PERIOD_END,   32'h0000_0003, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE,    REG_AMP_MIN,      32'h0000_5555, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE,    REG_AMP_MAX,      32'h0000_5555, 1'b0, 32'h0000_0000, 1'b0},
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'h0000_0005, 1'b1, 32'h0000_5555, 1'b0},
        '{ROW_ARGUMENT, REG_PERIOD_START, 32'hFFFF_FFFE, 1'b1, 32'h0000_5555, 1'b0}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    sro_arg_if  arg_ch ();
    sro_wave_if wave_ch ();

    sine_range_oscillator_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .arg_ch  (arg_ch),
        .wave_ch (wave_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow of the four registers as the predictor sees them
    logic signed [DATA_W-1:0] cfg_start   = PERIOD_START_RST;
    logic signed [DATA_W-1:0] cfg_end     = PERIOD_END_RST;
    logic signed [DATA_W-1:0] cfg_amp_min = AMP_MIN_RST;
    logic signed [DATA_W-1:0] cfg_amp_max = AMP_MAX_RST;

    int         sine_quarter [0:SINE_TABLE_DEPTH];
    wave_word_t wave_due [$];
    int         mismatches = 0;
    int         send_calm  = 0;
    int         take_calm  = 0;

    // quarter-wave sine in q16 from a truncated taylor series in q30
    function automatic void fill_sine_quarter();
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned acc;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            ang    = (QUARTER_TURN_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
            ang_sq = (ang * ang) >> 30;
            acc    = UNIT_Q30;
            for (int n = 0; n < 6; n++)
            begin
                acc = UNIT_Q30 - (((ang_sq * acc) >> 30) / 64'(TAYLOR_DIV[n]));
            end
            acc = (ang * acc) >> 30;
            acc = (acc + 64'd8192) >> 14;
            sine_quarter[k] = (acc > 64'd65536) ? 65536 : int'(acc);
        end
    endfunction

    // quotient rounded toward minus infinity, whatever the signs
    function automatic longint floor_quotient(input longint num, input longint den);
        longint quo;
        quo = num / den;
        if ((num % den != 0) && ((num < 0) != (den < 0)))
        begin
            quo = quo - 1;
        end
        return quo;
    endfunction

    // scaled sine for one argument under the current shadow setting
    function automatic wave_word_t predict_wave(input logic [DATA_W-1:0] arg);
        wave_word_t            res;
        longint                span;
        longint                offset;
        longint                quo;
        longint                sine;
        longint                spread;
        longint                total;
        logic [PHASE_BITS-1:0] ph;
        int                    slot;
        span = longint'(cfg_end) - longint'(cfg_start);
        if (span == 0)
        begin
            res.value = cfg_amp_min;
            res.err   = 1'b1;
            return res;
        end
        offset = longint'($signed(arg)) - longint'(cfg_start);
        quo    = floor_quotient(offset * (longint'(1) << PHASE_BITS), span);
        ph     = quo[PHASE_BITS-1:0];
        slot   = (int'(ph[FRAC_W-1:0]) * SINE_TABLE_DEPTH) >>> FRAC_W;
        if (slot >= SINE_TABLE_DEPTH)
        begin
            slot = SINE_TABLE_DEPTH - 1;
        end
        case (quadrant_t'(ph[PHASE_BITS-1 -: 2]))
            QUAD_RISE: sine = sine_quarter[slot];
            QUAD_FALL: sine = sine_quarter[SINE_TABLE_DEPTH - slot];
            QUAD_DIP:  sine = -longint'(sine_quarter[slot]);
            default:   sine = -longint'(sine_quarter[SINE_TABLE_DEPTH - slot]);
        endcase
        spread    = longint'(cfg_amp_max) - longint'(cfg_amp_min);
        // arithmetic shift floors the q17 product, negative ones included
        total     = longint'(cfg_amp_min) + ((spread * (sine + 65536)) >>> 17);
        res.value = total[DATA_W-1:0];
        res.err   = 1'b0;
        return res;
    endfunction

    // wait before the next word, drawn at random, with calm stretches of no waiting
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm = $urandom_range(10, 40);
        end
        return $urandom_range(0, 18);
    endfunction

    // register value biased towards the extremes
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // offer one argument word; the expectation is logged at the accepting edge
    task automatic send_argument(input logic [DATA_W-1:0] word, input logic typed,
                                 input wave_word_t want);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            arg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        arg_ch.valid    <= 1'b1;
        arg_ch.argument <= word;
        do
        begin
            @(posedge clk);
        end
        while (!arg_ch.ready);
        wave_due.push_back(typed ? want : predict_wave(word));
    endtask

    // apb write once the pipeline has drained, then read the register back
    task automatic program_register(input reg_idx_t target, input logic [DATA_W-1:0] word);
        arg_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (wave_due.size() != 0);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {target, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        case (target)
            REG_PERIOD_START: cfg_start   = word;
            REG_PERIOD_END:   cfg_end     = word;
            REG_AMP_MIN:      cfg_amp_min = word;
            default:          cfg_amp_max = word;
        endcase
        // read setup straight after the write access, psel stays up
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (prdata !== word)
        begin
            $display("%0t: readback of %s expected %h actual %h", $time, target.name(), word,
                     prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // stimulus: reset, directed table, then random phases each with a fresh setting
    initial
    begin
        logic [DATA_W-1:0] set_start;
        logic [DATA_W-1:0] set_end;
        logic [DATA_W-1:0] set_min;
        logic [DATA_W-1:0] set_max;
        logic [DATA_W-1:0] span;
        logic [DATA_W-1:0] word;
        longint            reach;
        longint            near;

        fill_sine_quarter();
        rst_n           = 1'b0;
        arg_ch.valid    = 1'b0;
        arg_ch.argument = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < DIRECTED_COUNT; n++)
        begin
            if (DIRECTED_ROWS[n].kind == ROW_WRITE)
            begin
                program_register(DIRECTED_ROWS[n].target, DIRECTED_ROWS[n].word);
            end
            else
            begin
                send_argument(DIRECTED_ROWS[n].word, DIRECTED_ROWS[n].typed,
                              {DIRECTED_ROWS[n].want_value, DIRECTED_ROWS[n].want_err});
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    // zero period length with random amplitudes
                    set_start = pick_word();
                    set_end   = set_start;
                    set_min   = $urandom;
                    set_max   = $urandom;
                end
                1:
                begin
                    set_start = 32'h8000_0000;
                    set_end   = 32'h7FFF_FFFF;
                    set_min   = 32'h8000_0000;
                    set_max   = 32'h7FFF_FFFF;
                end
                2:
                begin
                    set_start = 32'h7FFF_FFFF;
                    set_end   = 32'h8000_0000;
                    set_min   = 32'h7FFF_FFFF;
                    set_max   = 32'h8000_0000;
                end
                default:
                begin
                    set_start = pick_word();
                    case ($urandom_range(0, 3))
                        0:       span = $urandom_range(1, 64);
                        1:       span = $urandom_range(1, 32'h0010_0000);
                        2:       span = $urandom_range(32'h0000_8000, 32'h0100_0000);
                        default: span = $urandom;
                    endcase
                    // negative length gives a reversed period
                    if ($urandom_range(0, 1) == 1)
                    begin
                        span = -span;
                    end
                    set_end = set_start + span;
                    set_min = pick_word();
                    set_max = pick_word();
                end
            endcase
            program_register(REG_PERIOD_START, set_start);
            program_register(REG_PERIOD_END, set_end);
            program_register(REG_AMP_MIN, set_min);
            program_register(REG_AMP_MAX, set_max);

            // arguments mostly within three period lengths of the start, the reach capped at 2^30
            reach = longint'($signed(set_end)) - longint'($signed(set_start));
            if (reach < 0)
            begin
                reach = -reach;
            end
            reach = reach * 3;
            if (reach > (longint'(1) << 30))
            begin
                reach = longint'(1) << 30;
            end
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                case ($urandom_range(0, 7))
                    0, 1:
                    begin
                        word = $urandom;
                    end
                    2:
                    begin
                        word = ($urandom_range(0, 1) == 1) ? set_start : set_end;
                    end
                    default:
                    begin
                        near = longint'($signed(set_start))
                             + longint'($urandom_range(0, 32'(2 * reach))) - reach;
                        word = near[DATA_W-1:0];
                    end
                endcase
                send_argument(word, 1'b0, '0);
            end
        end

        arg_ch.valid <= 1'b0;
        while (wave_due.size() != 0)
        begin
            @(posedge clk);
        end
        // any stray word in this window fails the run
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("sine_range_oscillator_unit_tb OK");
        end
        else
        begin
            $display("sine_range_oscillator_unit_tb NOT OK");
        end
        $finish;
    end

    // result side: random stalls on ready, every accepted word checked against the oldest one due
    initial
    begin
        int         stall;
        wave_word_t due;

        wave_ch.ready = 1'b0;
        forever
        begin
            stall = draw_wait(take_calm);
            if (stall > 0)
            begin
                wave_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            wave_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!wave_ch.valid);
            if (wave_due.size() == 0)
            begin
                $display("%0t: wave word with none due, actual %h error %b", $time,
                         wave_ch.wave_value, wave_ch.period_error);
                mismatches++;
            end
            else
            begin
                due = wave_due.pop_front();
                if (wave_ch.wave_value !== due.value)
                begin
                    $display("%0t: wave_value expected %h actual %h", $time, due.value,
                             wave_ch.wave_value);
                    mismatches++;
                end
                if (wave_ch.period_error !== due.err)
                begin
                    $display("%0t: period_error expected %b actual %b", $time, due.err,
                             wave_ch.period_error);
                    mismatches++;
                end
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #TIMEOUT_NS;
        $display("sine_range_oscillator_unit_tb NOT OK");
        $finish;
    end

endmodule
